[design/qxmm_pkg.sv]
// Shared types and constants for the quad X motor mixer.
`default_nettype none

package qxmm_pkg;

	localparam int IN_W    = 20;
	localparam int OUT_W   = 16;
	localparam int LANES   = 4;
	localparam int C_W     = IN_W + 2;
	localparam int CMAG_W  = C_W - 1;
	localparam int SPAN_W  = C_W;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = CMAG_W / DIV_STEP;
	localparam int PIPE_LAT   = DIV_STAGES + 7;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [OUT_W-1:0] IDLE_RST  = 16'd1000;
	localparam logic [OUT_W-1:0] LIMIT_RST = 16'd2000;

	typedef enum logic [0:0] {
		REG_IDLE  = 1'b0,
		REG_LIMIT = 1'b1
	} qxmm_reg_t;

	typedef struct packed {
		logic signed [IN_W-1:0] roll_value;
		logic signed [IN_W-1:0] pitch_value;
		logic signed [IN_W-1:0] yaw_value;
		logic [OUT_W-1:0]       throttle_value;
		logic                   airmode_on;
	} qxmm_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] motor_one;
		logic [OUT_W-1:0] motor_two;
		logic [OUT_W-1:0] motor_three;
		logic [OUT_W-1:0] motor_four;
	} qxmm_out_t;

endpackage

`default_nettype wire

[design/quad_x_motor_mixer_airmode.sv]
// Top level of the quad X motor mixer with airmode desaturation.
// Stages S1 to S3, the divider and S4 to S7 lie between the accepting edge and the done strobe.
// Throughput: one item per cycle; busy never asserts and results cannot be held off.
// The depth is set by the 7-stage restoring divider, 3 quotient bits per stage.
// Reset clears all valid bits and loads idle = 1000, limit = 2000.
`default_nettype none

module quad_x_motor_mixer_airmode #(
	parameter int FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  qxmm_pkg::qxmm_in_t cmd,
	output logic done,
	output qxmm_pkg::qxmm_out_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [qxmm_pkg::ADDR_W-1:0] paddr,
	input  logic [qxmm_pkg::DATA_W-1:0] pwdata,
	output logic [qxmm_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import qxmm_pkg::*;

	localparam int FX_W  = OUT_W + FRAC_BITS;
	localparam int NUM_W = CMAG_W + FX_W;
	localparam int CMP_W = (FX_W > SPAN_W) ? FX_W : SPAN_W;
	localparam int ACC_W = ((FX_W > C_W) ? FX_W : C_W) + 3;

	typedef struct packed {
		logic [LANES-1:0][C_W-1:0] c;
		logic [LANES-1:0]          neg;
		logic                      scale;
		logic [OUT_W-1:0]          thr;
		logic                      air;
	} sb_t;

	function automatic logic signed [C_W-1:0] smin(
		input logic signed [C_W-1:0] a,
		input logic signed [C_W-1:0] b
	);
		return (b < a) ? b : a;
	endfunction

	function automatic logic signed [C_W-1:0] smax(
		input logic signed [C_W-1:0] a,
		input logic signed [C_W-1:0] b
	);
		return (b > a) ? b : a;
	endfunction

	// configuration
	logic [OUT_W-1:0] idle_q, limit_q, lim_eff;
	logic [FX_W-1:0]  idle_fx, lim_fx, range_fx;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= IDLE_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (qxmm_reg_t'(paddr[2]))
				REG_IDLE:  idle_q  <= pwdata[OUT_W-1:0];
				REG_LIMIT: limit_q <= pwdata[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (qxmm_reg_t'(paddr[2]))
			REG_IDLE:  prdata = DATA_W'(idle_q);
			REG_LIMIT: prdata = DATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// a limit below idle collapses the range to zero
	assign lim_eff  = (limit_q < idle_q) ? idle_q : limit_q;
	assign idle_fx  = FX_W'(idle_q) << FRAC_BITS;
	assign lim_fx   = FX_W'(lim_eff) << FRAC_BITS;
	assign range_fx = lim_fx - idle_fx;

	// S1: X-frame corrections
	logic                      v_s1;
	logic [LANES-1:0][C_W-1:0] c_s1;
	logic [OUT_W-1:0]          thr_s1;
	logic                      air_s1;
	logic signed [C_W-1:0]     r_w, p_w, y_w;

	assign r_w = C_W'(cmd.roll_value);
	assign p_w = C_W'(cmd.pitch_value);
	assign y_w = C_W'(cmd.yaw_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		c_s1[0] <= -p_w - r_w + y_w;
		c_s1[1] <=  p_w - r_w - y_w;
		c_s1[2] <= -p_w + r_w - y_w;
		c_s1[3] <=  p_w + r_w + y_w;
		thr_s1  <= cmd.throttle_value;
		air_s1  <= cmd.airmode_on;
	end

	// S2: span and magnitudes
	logic                         v_s2;
	logic [LANES-1:0][C_W-1:0]    c_s2;
	logic [LANES-1:0][CMAG_W-1:0] mag_s2;
	logic [LANES-1:0]             neg_s2;
	logic [SPAN_W-1:0]            span_s2;
	logic [OUT_W-1:0]             thr_s2;
	logic                         air_s2;
	logic signed [C_W-1:0]        mn1, mx1;
	logic signed [C_W:0]          span_full;

	always_comb begin
		mn1 = smin(smin(c_s1[0], c_s1[1]), smin(c_s1[2], c_s1[3]));
		mx1 = smax(smax(c_s1[0], c_s1[1]), smax(c_s1[2], c_s1[3]));
		span_full = (C_W+1)'(mx1) - (C_W+1)'(mn1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			neg_s2[l] <= c_s1[l][C_W-1];
			mag_s2[l] <= c_s1[l][C_W-1] ? CMAG_W'(-signed'(c_s1[l])) : CMAG_W'(c_s1[l]);
		end
		c_s2    <= c_s1;
		span_s2 <= span_full[SPAN_W-1:0];
		thr_s2  <= thr_s1;
		air_s2  <= air_s1;
	end

	// S3: numerators |c| * range, scale decision
	logic                        v_s3;
	logic [LANES-1:0][NUM_W-1:0] num_s3;
	logic [SPAN_W-1:0]           span_s3;
	sb_t                         sb_s [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			num_s3[l] <= NUM_W'(mag_s2[l]) * NUM_W'(range_fx);
		end
		span_s3        <= span_s2;
		sb_s[0].c      <= c_s2;
		sb_s[0].neg    <= neg_s2;
		sb_s[0].scale  <= CMP_W'(span_s2) > CMP_W'(range_fx);
		sb_s[0].thr    <= thr_s2;
		sb_s[0].air    <= air_s2;
	end

	// divider, side data delayed alongside
	logic                         dv_valid;
	logic [LANES-1:0][CMAG_W-1:0] quo;

	qxmm_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.num      (num_s3),
		.den      (span_s3),
		.out_valid(dv_valid),
		.quo      (quo)
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_sb
		always_ff @(posedge clk) begin
			sb_s[k+1] <= sb_s[k];
		end
	end

	// S4: apply sign, pick scaled or raw correction
	logic                      v_s4;
	logic [LANES-1:0][C_W-1:0] cs_s4;
	logic [OUT_W-1:0]          thr_s4;
	logic                      air_s4;
	sb_t                       sbo;

	assign sbo = sb_s[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (!sbo.scale) begin
				cs_s4[l] <= sbo.c[l];
			end else if (sbo.neg[l]) begin
				cs_s4[l] <= -C_W'(quo[l]);
			end else begin
				cs_s4[l] <= C_W'(quo[l]);
			end
		end
		thr_s4 <= sbo.thr;
		air_s4 <= sbo.air;
	end

	// S5: min and max of final corrections
	logic                      v_s5;
	logic [LANES-1:0][C_W-1:0] cs_s5;
	logic signed [C_W-1:0]     mn_s5, mx_s5;
	logic [OUT_W-1:0]          thr_s5;
	logic                      air_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		mn_s5  <= smin(smin(cs_s4[0], cs_s4[1]), smin(cs_s4[2], cs_s4[3]));
		mx_s5  <= smax(smax(cs_s4[0], cs_s4[1]), smax(cs_s4[2], cs_s4[3]));
		cs_s5  <= cs_s4;
		thr_s5 <= thr_s4;
		air_s5 <= air_s4;
	end

	// S6: collective
	logic                      v_s6;
	logic [LANES-1:0][C_W-1:0] cs_s6;
	logic signed [ACC_W-1:0]   coll_s6;
	logic signed [ACC_W-1:0]   idle_a, lim_a, thr_a, lo_a, hi_a, raised;

	assign idle_a = ACC_W'(idle_fx);
	assign lim_a  = ACC_W'(lim_fx);
	assign thr_a  = ACC_W'(FX_W'(thr_s5) << FRAC_BITS);

	always_comb begin
		if (air_s5) begin
			lo_a = idle_a - ACC_W'(mn_s5);
			hi_a = lim_a - ACC_W'(mx_s5);
		end else begin
			lo_a = idle_a;
			hi_a = lim_a;
		end
		// raise first, then lower
		raised = (thr_a < lo_a) ? lo_a : thr_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		coll_s6 <= (raised > hi_a) ? hi_a : raised;
		cs_s6   <= cs_s5;
	end

	// S7: per-motor clamp and truncate into the output register
	logic [LANES-1:0][OUT_W-1:0] mot;
	logic signed [ACC_W-1:0]     v_sum [LANES];
	logic                        done_q;
	qxmm_out_t                   result_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			v_sum[l] = coll_s6 + ACC_W'(signed'(cs_s6[l]));
			if (v_sum[l] < idle_a) begin
				mot[l] = idle_q;
			end else if (v_sum[l] > lim_a) begin
				mot[l] = lim_eff;
			end else begin
				mot[l] = v_sum[l][FRAC_BITS +: OUT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6) begin
			result_q.motor_one   <= mot[0];
			result_q.motor_two   <= mot[1];
			result_q.motor_three <= mot[2];
			result_q.motor_four  <= mot[3];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[design/qxmm_div.sv]
// Pipelined unsigned restoring divider, four lanes sharing one divisor.
`default_nettype none

module qxmm_div #(
	parameter int NUM_W = 41
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [qxmm_pkg::LANES-1:0][NUM_W-1:0] num,
	input  logic [qxmm_pkg::SPAN_W-1:0] den,
	output logic out_valid,
	output logic [qxmm_pkg::LANES-1:0][qxmm_pkg::CMAG_W-1:0] quo
);
	import qxmm_pkg::*;

	// Quotient is known to fit CMAG_W bits, so the upper numerator bits
	// already sit below the divisor and seed the remainder.
	function automatic logic [SPAN_W+CMAG_W-1:0] div_steps(
		input logic [SPAN_W-1:0] rem,
		input logic [CMAG_W-1:0] wrk,
		input logic [SPAN_W-1:0] dv
	);
		logic [SPAN_W-1:0] r;
		logic [CMAG_W-1:0] w;
		logic [SPAN_W:0]   t;
		r = rem;
		w = wrk;
		for (int i = 0; i < DIV_STEP; i++) begin
			t = {r, w[CMAG_W-1]};
			if (t >= {1'b0, dv}) begin
				r = SPAN_W'(t - {1'b0, dv});
				w = {w[CMAG_W-2:0], 1'b1};
			end else begin
				r = t[SPAN_W-1:0];
				w = {w[CMAG_W-2:0], 1'b0};
			end
		end
		return {r, w};
	endfunction

	logic                                 vld_s [DIV_STAGES+1];
	logic [SPAN_W-1:0]                    den_s [DIV_STAGES+1];
	logic [LANES-1:0][SPAN_W-1:0]         rem_s [DIV_STAGES+1];
	logic [LANES-1:0][CMAG_W-1:0]         wrk_s [DIV_STAGES+1];

	always_comb begin
		vld_s[0] = in_valid;
		den_s[0] = den;
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = SPAN_W'(num[l] >> CMAG_W);
			wrk_s[0][l] = num[l][CMAG_W-1:0];
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [LANES-1:0][SPAN_W+CMAG_W-1:0] nxt;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				nxt[l] = div_steps(rem_s[k][l], wrk_s[k][l], den_s[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			for (int l = 0; l < LANES; l++) begin
				rem_s[k+1][l] <= nxt[l][SPAN_W+CMAG_W-1:CMAG_W];
				wrk_s[k+1][l] <= nxt[l][CMAG_W-1:0];
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign quo       = wrk_s[DIV_STAGES];

endmodule

`default_nettype wire

[design/qxmm_chk.sv]
// Port-level checker for the motor mixer, bound to the top level.
`default_nettype none

module qxmm_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input qxmm_pkg::qxmm_in_t cmd,
	input logic done,
	input qxmm_pkg::qxmm_out_t result
);
	import qxmm_pkg::*;

	logic accept;
	logic zero_cmd;

	assign accept   = start && !busy;
	assign zero_cmd = (cmd.roll_value == '0) && (cmd.pitch_value == '0) &&
		(cmd.yaw_value == '0);

	// every accepted item gives a result after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LAT done)
		else $error("accepted item produced no result on time");

	// no result without an item accepted exactly one latency earlier
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("result without a matching accepted item");

	// result only moves with the strobe
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(done) && !done |-> $stable(result))
		else $error("result changed without a strobe");

	// no differential command means all four motors match
	a_equal: assert property (@(posedge clk) disable iff (!arst_n)
		accept && zero_cmd |-> ##PIPE_LAT
			(result.motor_one == result.motor_two) &&
			(result.motor_one == result.motor_three) &&
			(result.motor_one == result.motor_four))
		else $error("motors differ for a zero attitude command");

endmodule

bind quad_x_motor_mixer_airmode qxmm_chk u_qxmm_chk (.*);

`default_nettype wire
